// File: rtl/afsm_pkg.sv
// Shared types and constants for the APU frame sequencer and stereo mixer.
package afsm_pkg;

    // Channel and field sizes.
    localparam int NUM_CH    = 4;
    localparam int LEVEL_W   = 4;
    localparam int VOL_W     = 3;
    localparam int SAMPLE_W  = 15;
    localparam int BASE_BITS = 12;
    localparam int STEP_W    = 3;

    // Mixer scaling: each level step is worth 512, the mix is centered by this offset.
    localparam int MIX_SCALE_SH = 9;
    localparam int MIX_OFFSET   = 15360;

    // Configuration port sizes.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 4;

    // Frame steps with special meaning.
    localparam logic [STEP_W-1:0] STEP_ENVELOPE = 3'd7;

    typedef logic [NUM_CH-1:0][LEVEL_W-1:0] levels_t;
    typedef logic [NUM_CH-1:0]              route_t;
    typedef logic [VOL_W-1:0]               vol_t;
    typedef logic signed [SAMPLE_W-1:0]     sample_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LEFT_VOLUME   = 3'd0,
        CFG_RIGHT_VOLUME  = 3'd1,
        CFG_LEFT_ROUTE    = 3'd2,
        CFG_RIGHT_ROUTE   = 3'd3,
        CFG_RUN_ENABLE    = 3'd4,
        CFG_MASTER_ENABLE = 3'd5
    } cfg_index_t;

    // Input stage contents: the levels plus the frame strobes taken at accept time.
    typedef struct packed {
        levels_t levels;
        logic    length_tick;
        logic    sweep_tick;
        logic    envelope_tick;
    } stage_t;

endpackage

// File: rtl/afsm_mix.sv
// One side of the stereo mixer: route, scale, offset and attenuate.
module afsm_mix
(
    input  afsm_pkg::levels_t levels,
    input  afsm_pkg::route_t  route,
    input  afsm_pkg::vol_t    volume,
    input  logic              enable,
    output afsm_pkg::sample_t sample
);
    import afsm_pkg::*;

    localparam int SUM_W = LEVEL_W + $clog2(NUM_CH);
    localparam int MIX_W = SAMPLE_W + 1;

    logic [SUM_W-1:0]        sum;
    logic signed [MIX_W-1:0] scaled;
    logic signed [MIX_W-1:0] att;

    // Add up the levels of the routed channels.
    always_comb
    begin
        sum = '0;
        for (int i = 0; i < NUM_CH; i++)
        begin
            if (route[i])
            begin
                sum = sum + SUM_W'(levels[i]);
            end
        end
    end

    // Scale by 512 and center around zero.
    assign scaled = $signed(MIX_W'({sum, {MIX_SCALE_SH{1'b0}}})) - $signed(MIX_W'(MIX_OFFSET));

    // Attenuate in eighths of full scale with floor shifts.
    always_comb
    begin
        case (volume)
            3'd0:    att = scaled >>> 3;
            3'd1:    att = scaled >>> 2;
            3'd2:    att = (scaled >>> 2) + (scaled >>> 3);
            3'd3:    att = scaled >>> 1;
            3'd4:    att = (scaled >>> 1) + (scaled >>> 3);
            3'd5:    att = scaled - (scaled >>> 2);
            3'd6:    att = scaled - (scaled >>> 3);
            default: att = scaled;
        endcase
    end

    // The sample range always fits, so plain truncation is exact.
    assign sample = enable ? att[SAMPLE_W-1:0] : '0;

endmodule

// File: rtl/apu_frame_sequencer_mixer.sv
// Top level: frame sequencer counters, input stage, stereo mixers and result register.
// Throughput: one beat per cycle while m_tready is high. The input stage feeds the result
// register that drives m_tvalid; each holds one beat, and while a result waits for m_tready
// a new beat is taken only if the input stage is empty.
// Reset: rst_n clears the configuration registers, both frame counters and all valid flags.
// The frame strobes follow the counters at the moment a beat is accepted.
module apu_frame_sequencer_mixer
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic                                cfg_wr_en,
    input  logic [afsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [afsm_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // square1_level, square2_level, wave_level, noise_level
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // length_tick, sweep_tick, envelope_tick, run_strobes,
                                  // left_sample, right_sample, zero fill
);
    import afsm_pkg::*;

    // Configuration registers.
    vol_t   left_volume_reg;
    vol_t   right_volume_reg;
    route_t left_route_reg;
    route_t right_route_reg;
    route_t run_enable_reg;
    logic   master_enable_reg;

    // Frame sequencer state.
    logic [BASE_BITS-1:0] base_counter_reg;
    logic [BASE_BITS-1:0] base_counter_next;
    logic [STEP_W-1:0]    frame_step_reg;
    logic [STEP_W-1:0]    frame_step_next;

    // Pipeline registers.
    logic   s1_valid_reg;
    stage_t s1_reg;
    stage_t s1_next;
    logic   out_valid_reg;
    logic [39:0] out_data_reg;
    logic [39:0] out_data_next;

    logic    s_fire;
    logic    s1_take;
    logic    base_zero;
    sample_t left_sample;
    sample_t right_sample;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_volume_reg   <= '0;
            right_volume_reg  <= '0;
            left_route_reg    <= '0;
            right_route_reg   <= '0;
            run_enable_reg    <= '0;
            master_enable_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_LEFT_VOLUME:   left_volume_reg   <= cfg_data[VOL_W-1:0];
                CFG_RIGHT_VOLUME:  right_volume_reg  <= cfg_data[VOL_W-1:0];
                CFG_LEFT_ROUTE:    left_route_reg    <= cfg_data[NUM_CH-1:0];
                CFG_RIGHT_ROUTE:   right_route_reg   <= cfg_data[NUM_CH-1:0];
                CFG_RUN_ENABLE:    run_enable_reg    <= cfg_data[NUM_CH-1:0];
                CFG_MASTER_ENABLE: master_enable_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Handshake: the input stage frees up when it is empty or moving into the result register.
    assign s1_take  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_take;
    assign s_fire   = s_tvalid && s_tready;

    // Frame strobes and counter advance for the beat being accepted.
    assign base_zero         = (base_counter_reg == '0);
    assign base_counter_next = base_counter_reg + BASE_BITS'(1);
    assign frame_step_next   = base_zero ? frame_step_reg + STEP_W'(1) : frame_step_reg;

    always_comb
    begin
        s1_next.levels        = s_tdata;
        s1_next.length_tick   = base_zero && !frame_step_reg[0];
        s1_next.sweep_tick    = base_zero && (frame_step_reg[1:0] == 2'b10);
        s1_next.envelope_tick = base_zero && (frame_step_reg == STEP_ENVELOPE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_counter_reg <= '0;
            frame_step_reg   <= '0;
        end
        else if (s_fire)
        begin
            base_counter_reg <= base_counter_next;
            frame_step_reg   <= frame_step_next;
        end
    end

    // Input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_reg <= s1_next;
        end
    end

    // Left and right mixers.
    afsm_mix u_mix_left
    (
        .levels (s1_reg.levels),
        .route  (left_route_reg),
        .volume (left_volume_reg),
        .enable (master_enable_reg),
        .sample (left_sample)
    );

    afsm_mix u_mix_right
    (
        .levels (s1_reg.levels),
        .route  (right_route_reg),
        .volume (right_volume_reg),
        .enable (master_enable_reg),
        .sample (right_sample)
    );

    // Pack the result beat.
    assign out_data_next = {3'b000, right_sample, left_sample, run_enable_reg,
                            s1_reg.envelope_tick, s1_reg.sweep_tick, s1_reg.length_tick};

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The envelope step is odd, so it never carries a length strobe.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !(s1_reg.envelope_tick && s1_reg.length_tick))
        else $error("envelope and length strobes fired together");

    // Sweep steps are a subset of the length steps.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_reg.sweep_tick |-> s1_reg.length_tick)
        else $error("sweep strobe without length strobe");

    // The frame step only moves on a beat taken while the base counter reads zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_fire && base_zero) |=> $stable(frame_step_reg))
        else $error("frame step moved without a base counter wrap");

    // Each accepted beat advances the base counter by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> base_counter_reg == $past(base_counter_next))
        else $error("base counter did not advance on an accepted beat");

endmodule
